@@ design/sorted_unique_key_set_unit_assert.svh @@
// Assertion macros for the port-level checker of the key set unit.
// Every macro samples on clk and is disabled while rst is high.
`ifndef SORTED_UNIQUE_KEY_SET_UNIT_ASSERT_SVH
`define SORTED_UNIQUE_KEY_SET_UNIT_ASSERT_SVH

// Same-cycle implication
`define SUKS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("suks check failed in %m");

// Next-cycle implication
`define SUKS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("suks check failed in %m");

`endif

@@ design/suks_pkg.sv @@
// Shared types and codes for the sorted unique key set unit.
// Used by the controller, the datapath and the top level; no dependencies.
package suks_pkg;

  // Item operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load_item;   // capture item, lo = 0, hi = count
    logic rd_probe;    // read the middle entry, register mid
    logic take_right;  // lo = mid + 1
    logic take_left;   // hi = mid
    logic shift_init;  // ptr = count
    logic rd_shift;    // read entry ptr - 1
    logic wr_shift;    // write read data to entry ptr, ptr--
    logic wr_key;      // write key to entry lo, count++
    logic set_hit;     // result: found at mid
    logic set_miss;    // result: not found, nothing stored
    logic set_ins;     // result: inserted at lo
    logic set_drop;    // result: refused, store full
    logic out_load;    // move the result into the output register
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic lo_lt_hi;
    logic hit;
    logic key_gt;
    logic full;
    logic ptr_gt_lo;
    logic op_lookup;
    logic out_free;
  } status_t;

endpackage

@@ design/suks_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module suks_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/suks_dp.sv @@
// Datapath of the key set unit: search bounds, shift pointer, entry count,
// key store RAM and output register. Uses suks_pkg and suks_ram.
module suks_dp #(
  parameter int CAPACITY = 64,
  parameter int KEY_BITS = 31
) (
  input  logic                           clk,
  input  logic                           rst,
  input  suks_pkg::cmd_t                 cmd,
  output suks_pkg::status_t              status,
  input  logic                           op,
  input  logic [KEY_BITS-1:0]            key,
  input  logic                           out_stall,
  output logic                           out_valid,
  output logic                           found,
  output logic [$clog2(CAPACITY)-1:0]    position,
  output logic [$clog2(CAPACITY+1)-1:0]  entries_now,
  output logic                           dropped_full
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic                op_r;
  logic [KEY_BITS-1:0] key_r;
  logic [CW-1:0]       lo;
  logic [CW-1:0]       hi;
  logic [CW-1:0]       ptr;
  logic [CW-1:0]       count;
  logic [AW-1:0]       mid;
  logic [CW:0]         bound_sum;
  logic [AW-1:0]       mid_next;
  logic [CW-1:0]       ptr_dec;
  logic                res_found;
  logic [AW-1:0]       res_pos;
  logic                res_drop;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [KEY_BITS-1:0] ram_wdata;
  logic                ram_re;
  logic [AW-1:0]       ram_raddr;
  logic [KEY_BITS-1:0] ram_rdata;

  // Middle of the open range; always below CAPACITY
  assign bound_sum = {1'b0, lo} + {1'b0, hi};
  assign mid_next  = bound_sum[AW:1];
  assign ptr_dec   = ptr - CW'(1);

  // Key store port muxes
  assign ram_re    = cmd.rd_probe | cmd.rd_shift;
  assign ram_raddr = cmd.rd_shift ? ptr_dec[AW-1:0] : mid_next;
  assign ram_we    = cmd.wr_shift | cmd.wr_key;
  assign ram_waddr = cmd.wr_shift ? ptr[AW-1:0] : lo[AW-1:0];
  assign ram_wdata = cmd.wr_shift ? ram_rdata : key_r;

  suks_ram #(
    .WIDTH (KEY_BITS),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Status back to the controller
  assign status.lo_lt_hi  = lo < hi;
  assign status.hit       = ram_rdata == key_r;
  assign status.key_gt    = key_r > ram_rdata;
  assign status.full      = count == CW'(CAPACITY);
  assign status.ptr_gt_lo = ptr > lo;
  assign status.op_lookup = op_r == suks_pkg::OP_LOOKUP;
  assign status.out_free  = !out_valid || !out_stall;

  // Search state and item capture
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op_r  <= op;
      key_r <= key;
      lo    <= '0;
      hi    <= count;
    end
    if (cmd.rd_probe) begin
      mid <= mid_next;
    end
    if (cmd.take_right) begin
      lo <= CW'(mid) + CW'(1);
    end
    if (cmd.take_left) begin
      hi <= CW'(mid);
    end
    if (cmd.shift_init) begin
      ptr <= count;
    end else if (cmd.wr_shift) begin
      ptr <= ptr_dec;
    end
  end

  // Pending result of the current item
  always_ff @(posedge clk) begin
    if (cmd.set_hit) begin
      res_found <= 1'b1;
      res_pos   <= mid;
      res_drop  <= 1'b0;
    end
    if (cmd.set_ins) begin
      res_found <= 1'b0;
      res_pos   <= lo[AW-1:0];
      res_drop  <= 1'b0;
    end
    if (cmd.set_miss || cmd.set_drop) begin
      res_found <= 1'b0;
      res_pos   <= '0;
      res_drop  <= cmd.set_drop;
    end
  end

  // Entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.wr_key) begin
      count <= count + CW'(1);
    end
  end

  // Output register: hold while stalled, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      found        <= res_found;
      position     <= res_pos;
      entries_now  <= count;
      dropped_full <= res_drop;
    end
  end

endmodule

@@ design/suks_ctrl.sv @@
// Controller of the key set unit: sequences the binary search, the upward
// shift of larger keys and the hand-off of each result. Uses suks_pkg.
module suks_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  suks_pkg::status_t status,
  output suks_pkg::cmd_t    cmd
);

  typedef enum logic [2:0] {
    IDLE,
    PROBE,
    CMP,
    SHIFT_RD,
    SHIFT_WR,
    DONE
  } state_t;

  state_t state;
  state_t state_next;

  assign in_stall = state != IDLE;

  // Next state and commands
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = PROBE;
        end
      end
      PROBE: begin
        if (status.lo_lt_hi) begin
          cmd.rd_probe = 1'b1;
          state_next   = CMP;
        end else if (status.op_lookup) begin
          cmd.set_miss = 1'b1;
          state_next   = DONE;
        end else if (status.full) begin
          cmd.set_drop = 1'b1;
          state_next   = DONE;
        end else begin
          cmd.shift_init = 1'b1;
          state_next     = SHIFT_RD;
        end
      end
      CMP: begin
        if (status.hit) begin
          cmd.set_hit = 1'b1;
          state_next  = DONE;
        end else if (status.key_gt) begin
          cmd.take_right = 1'b1;
          state_next     = PROBE;
        end else begin
          cmd.take_left = 1'b1;
          state_next    = PROBE;
        end
      end
      SHIFT_RD: begin
        if (status.ptr_gt_lo) begin
          cmd.rd_shift = 1'b1;
          state_next   = SHIFT_WR;
        end else begin
          cmd.wr_key  = 1'b1;
          cmd.set_ins = 1'b1;
          state_next  = DONE;
        end
      end
      SHIFT_WR: begin
        cmd.wr_shift = 1'b1;
        state_next   = SHIFT_RD;
      end
      DONE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ design/sorted_unique_key_set_unit.sv @@
// Sorted unique key set: keeps up to CAPACITY distinct keys in ascending
// order in one RAM. Input channel (in_valid/in_stall) carries op and key;
// op insert stores a new key, op lookup only searches. Output channel
// (out_valid/out_stall) returns one item per input item: found, position,
// entries_now and dropped_full.
// Sequence: one item is in work at a time. A binary search does a RAM
// read, then a compare, per probe, up to clog2(CAPACITY)+1 probes. An
// insert of a new key then moves each larger key up one place, with a
// read and then a write per key through the single RAM read and write
// port, and last writes the key.
// The output register parts the channels: the next item is accepted while
// a result still waits; a finished item waits only if the previous result
// is still stalled. Reset empties the set at once (entry count to zero,
// no clearing pass) and drops any pending result.
// Uses suks_pkg, suks_ctrl, suks_dp.
module sorted_unique_key_set_unit #(
  parameter int CAPACITY = 64,
  parameter int KEY_BITS = 31
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          op,
  input  logic [KEY_BITS-1:0]           key,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          found,
  output logic [$clog2(CAPACITY)-1:0]   position,
  output logic [$clog2(CAPACITY+1)-1:0] entries_now,
  output logic                          dropped_full
);

  suks_pkg::cmd_t    cmd;
  suks_pkg::status_t status;

  suks_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  suks_dp #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .op           (op),
    .key          (key),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .found        (found),
    .position     (position),
    .entries_now  (entries_now),
    .dropped_full (dropped_full)
  );

endmodule

@@ design/suks_checker.sv @@
// Port-level checks for the sorted unique key set unit, bound to the top.
// Uses the macros of sorted_unique_key_set_unit_assert.svh.
`include "sorted_unique_key_set_unit_assert.svh"

module suks_checker #(
  parameter int CAPACITY = 64,
  parameter int KEY_BITS = 31
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          op,
  input logic [KEY_BITS-1:0]           key,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic                          found,
  input logic [$clog2(CAPACITY)-1:0]   position,
  input logic [$clog2(CAPACITY+1)-1:0] entries_now,
  input logic                          dropped_full
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

  logic [AW+CW+1:0] result_bits;
  logic             drop_fields_ok;

  // Gather the result fields for the hold check
  assign result_bits    = {found, position, entries_now, dropped_full};
  assign drop_fields_ok = !found && position == '0 && entries_now == FULL_COUNT;

  // A stalled result holds
  `SUKS_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(result_bits))

  // A stalled input item holds
  `SUKS_ASSERT_NXT(a_in_hold, in_valid && in_stall, in_valid && $stable(op) && $stable(key))

  // One item in work: an accepted item closes the input side
  `SUKS_ASSERT_NXT(a_one_item, in_valid && !in_stall, in_stall)

  // Count never exceeds the capacity
  `SUKS_ASSERT_NOW(a_count_cap, out_valid, entries_now <= FULL_COUNT)

  // A refused insert reports a full store and no position
  `SUKS_ASSERT_NOW(a_drop_full, out_valid && dropped_full, drop_fields_ok)

endmodule

bind sorted_unique_key_set_unit suks_checker #(
  .CAPACITY (CAPACITY),
  .KEY_BITS (KEY_BITS)
) u_suks_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .op           (op),
  .key          (key),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .found        (found),
  .position     (position),
  .entries_now  (entries_now),
  .dropped_full (dropped_full)
);
